>>> hw/rtl/epvk_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Encoder position / velocity package
// Beat types, register map and fixed constants shared by the block's files.
// ----------------------------------------------------------------------------
package epvk_pkg;

  // Input beat: sample tick or reference marker with the raw counter value
  typedef struct packed {
    logic        kind;
    logic [15:0] reading;
  } in_item_t;

  // Result beat
  typedef struct packed {
    logic signed [31:0] position_mm;
    logic signed [31:0] velocity_est;
    logic signed [31:0] reference_mm;
    logic               reference_seen;
    logic               control_tick;
  } out_item_t;

  // Item kinds
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_MARKER = 1'b1;

  // Register map: word index taken from paddr[4:2]
  localparam int unsigned ADDR_W = 5;
  localparam logic [2:0] REG_POSITION_SCALE    = 3'd0;
  localparam logic [2:0] REG_VELOCITY_GAIN     = 3'd1;
  localparam logic [2:0] REG_PROCESS_NOISE     = 3'd2;
  localparam logic [2:0] REG_MEASUREMENT_NOISE = 3'd3;
  localparam logic [2:0] REG_CONTROL_DIVIDER   = 3'd4;

  // Register reset values
  localparam logic [31:0] RST_POSITION_SCALE    = 32'd4294967;
  localparam logic [31:0] RST_VELOCITY_GAIN     = 32'd65536;
  localparam logic [31:0] RST_PROCESS_NOISE     = 32'd16777;
  localparam logic [31:0] RST_MEASUREMENT_NOISE = 32'd16777216;
  localparam logic [15:0] RST_CONTROL_DIVIDER   = 16'd10;

  // Kalman gain is unsigned Q0.24, so unity is 2^24 (25 bits)
  localparam logic [24:0] K_ONE       = 25'h100_0000;
  localparam int unsigned K_BITS      = 25;

endpackage : epvk_pkg
`default_nettype wire

>>> hw/rtl/epvk_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Serial shift-add multiplier
// Unsigned product, one multiplier bit retired per cycle, LSB first.
// ----------------------------------------------------------------------------
module epvk_mul #(
  parameter int unsigned MCAND_W  = 32,
  parameter int unsigned MPLIER_W = 33
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [MCAND_W-1:0]            mcand,
  input  wire logic [MPLIER_W-1:0]           mplier,
  output logic                               busy,
  output logic [MCAND_W+MPLIER_W-1:0]        product
);

  localparam int unsigned PROD_W = MCAND_W + MPLIER_W;
  localparam int unsigned CNT_W  = $clog2(MPLIER_W + 1);

  logic [MCAND_W-1:0] mcand_r, mcand_nxt;
  logic [PROD_W-1:0]  prod_r, prod_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;

  logic [MCAND_W-1:0] addend;
  logic [MCAND_W:0]   psum;

  // Add the multiplicand into the upper half when the low bit is set
  assign addend = prod_r[0] ? mcand_r : '0;
  assign psum   = {1'b0, prod_r[PROD_W-1:MPLIER_W]} + {1'b0, addend};

  always_comb begin
    mcand_nxt = mcand_r;
    prod_nxt  = prod_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    if (start) begin
      mcand_nxt = mcand;
      prod_nxt  = {{MCAND_W{1'b0}}, mplier};
      cnt_nxt   = CNT_W'(MPLIER_W);
      busy_nxt  = 1'b1;
    end else if (busy_r) begin
      prod_nxt = {psum, prod_r[MPLIER_W-1:1]};
      cnt_nxt  = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    mcand_r <= mcand_nxt;
    prod_r  <= prod_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
    end
  end

  assign busy    = busy_r;
  assign product = prod_r;

endmodule : epvk_mul
`default_nettype wire

>>> hw/rtl/encoder_position_velocity_kalman.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Encoder position and Kalman velocity
// Unwraps encoder readings, scales position, filters velocity, marks periods.
// ----------------------------------------------------------------------------
// Usage
//   in_*  : one beat per encoder event. kind 0 is a sample tick, kind 1 a
//           reference marker. Every accepted beat yields exactly one result.
//   out_* : result beat: position, filtered velocity, latched reference,
//           reference flag and the control period tick.
//   cfg_* : APB-style register port, pready tied high. Registers sit at byte
//           address 4*index. The user writes only while the block is idle.
// Sequence (the block itself does not enforce the idle-only write rule)
//   A sample beat uses both 33-step serial multipliers: first the
//   count-change product and the position product run side by side (the
//   gain divider, 25 steps, finishes under them), then the filter update
//   and variance products run side by side. A marker beat uses only the
//   position product. One beat is worked on at a time, in_ready high only
//   while idle: a new beat is taken only after the last result has moved
//   on to the output register.
// Stall and reset
//   The result waits in the output register while the receiver stalls;
//   the next beat is accepted and computed meanwhile, and its result holds
//   until the output register frees. Synchronous active-low reset clears
//   all tracking state to zero and the registers to their defaults.
// ----------------------------------------------------------------------------
module encoder_position_velocity_kalman
  import epvk_pkg::*;
#(
  parameter int unsigned COUNTER_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // input beats
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire in_item_t          in_data,
  // result beats
  output logic                   out_valid,
  input  wire logic              out_ready,
  output out_item_t              out_data,
  // register port
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [ADDR_W-1:0] cfg_paddr,
  input  wire logic [31:0]       cfg_pwdata,
  output logic [31:0]            cfg_prdata,
  output logic                   cfg_pready
);

  localparam int unsigned CB = COUNTER_BITS;
  localparam logic [CB-1:0] HALF = CB'(1) << (CB - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_REFMUL,
    S_REFEND,
    S_KRUN,
    S_ZEND,
    S_UPD,
    S_SEND,
    S_FIN
  } state_t;

  // --------------------------------------------------------------------------
  // Saturation and rounding helpers
  // --------------------------------------------------------------------------
  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    if (v > 34'sh0_7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -34'sh0_8000_0000) begin
      return 32'sh8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

  function automatic logic signed [31:0] sat40(input logic signed [39:0] v);
    if (v > 40'sh00_7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -40'sh00_8000_0000) begin
      return 32'sh8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

  // |count| * scale, rounded half away from zero to Q16.16, saturated
  function automatic logic signed [31:0] pos_round(input logic [64:0] m,
                                                    input logic       neg);
    logic [65:0] rs;
    logic [49:0] r;
    rs = {1'b0, m} + 66'd32768;
    r  = rs[65:16];
    if (!neg && r > 50'h0_7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (neg && r > 50'h0_8000_0000) begin
      return 32'sh8000_0000;
    end else if (neg) begin
      return 32'(32'd0 - r[31:0]);
    end else begin
      return r[31:0];
    end
  endfunction

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  state_t             state_r, state_nxt;

  logic [31:0]        scale_r, scale_nxt;
  logic [31:0]        gain_r, gain_nxt;
  logic [31:0]        qn_r, qn_nxt;
  logic [31:0]        rn_r, rn_nxt;
  logic [15:0]        cdiv_r, cdiv_nxt;

  logic [CB-1:0]      last_r, last_nxt;
  logic signed [31:0] acc_r, acc_nxt;
  logic signed [31:0] prev_r, prev_nxt;
  logic signed [39:0] x_r, x_nxt;
  logic [31:0]        var_r, var_nxt;
  logic signed [31:0] ref_r, ref_nxt;
  logic               seen_r, seen_nxt;
  logic [15:0]        tick_r, tick_nxt;

  logic               kind_r, kind_nxt;
  logic               zneg_r, zneg_nxt;
  logic               dneg_r, dneg_nxt;
  logic               accneg_r, accneg_nxt;
  logic [31:0]        p_r, p_nxt;
  logic [32:0]        den_r, den_nxt;
  logic [33:0]        rem_r, rem_nxt;
  logic [K_BITS-1:0]  q_r, q_nxt;
  logic [4:0]         dcnt_r, dcnt_nxt;
  logic signed [31:0] pos_r, pos_nxt;
  out_item_t          res_r, res_nxt;

  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;

  // --------------------------------------------------------------------------
  // Combinational terms
  // --------------------------------------------------------------------------
  logic                in_fire;
  logic                cfg_wr;

  // unwrap
  logic [CB-1:0]       rd;
  logic [CB-1:0]       dmod;
  logic signed [CB:0]  step;
  logic signed [33:0]  acc_sum;

  // prep
  logic signed [32:0]  acc33;
  logic [32:0]         acc_mag;
  logic signed [33:0]  delta;
  logic [33:0]         delta_mag;
  logic [32:0]         psum;
  logic [31:0]         p_sat;

  // divider step
  logic                div_ge;
  logic [33:0]         div_rem;

  // measurement and innovation
  logic [73:0]         zm;
  logic signed [39:0]  z;
  logic signed [40:0]  diff;
  logic [40:0]         diff_mag;
  logic [K_BITS-1:0]   kgain;
  logic [73:0]         sm_round;
  logic [39:0]         sm;
  logic [15:0]         tick_inc;
  logic [15:0]         div_eff;

  // multiplier lanes: A for count change and update, B for position and variance
  logic                a_start, b_start;
  logic [40:0]         a_mcand;
  logic [32:0]         a_mplier;
  logic [31:0]         b_mcand;
  logic [32:0]         b_mplier;
  logic                a_busy, b_busy;
  logic [73:0]         a_prod;
  logic [64:0]         b_prod;

  epvk_mul #(
    .MCAND_W  (41),
    .MPLIER_W (33)
  ) u_mul_a (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (a_start),
    .mcand   (a_mcand),
    .mplier  (a_mplier),
    .busy    (a_busy),
    .product (a_prod)
  );

  epvk_mul #(
    .MCAND_W  (32),
    .MPLIER_W (33)
  ) u_mul_b (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (b_start),
    .mcand   (b_mcand),
    .mplier  (b_mplier),
    .busy    (b_busy),
    .product (b_prod)
  );

  assign in_fire = in_valid && in_ready;
  assign cfg_wr  = cfg_psel && cfg_penable && cfg_pwrite;

  // Unwrap: a step of exactly half the range counts as positive
  assign rd      = CB'(in_data.reading);
  assign dmod    = rd - last_r;
  assign step    = (dmod > HALF) ? {1'b1, dmod} : {1'b0, dmod};
  assign acc_sum = 34'(acc_r) + 34'(step);

  // Magnitudes for the serial products
  assign acc33     = 33'(acc_r);
  assign acc_mag   = acc_r[31] ? 33'(-acc33) : 33'(acc33);
  assign delta     = 34'(acc_r) - 34'(prev_r);
  assign delta_mag = delta[33] ? 34'(-delta) : 34'(delta);

  // Predicted variance, saturated, and the gain denominator
  assign psum  = {1'b0, var_r} + {1'b0, qn_r};
  assign p_sat = psum[32] ? 32'hFFFF_FFFF : psum[31:0];

  // Restoring divider, one quotient bit a cycle: k = p * 2^24 / (p + R)
  assign div_ge  = rem_r >= {1'b0, den_r};
  assign div_rem = div_ge ? (rem_r - {1'b0, den_r}) : rem_r;

  // Measurement z = delta * gain, saturated to 40 bits
  assign zm = a_prod;
  always_comb begin
    if (!zneg_r) begin
      z = (zm > 74'h7F_FFFF_FFFF) ? 40'sh7F_FFFF_FFFF : zm[39:0];
    end else begin
      z = (zm > 74'h80_0000_0000) ? 40'sh80_0000_0000 : 40'(40'd0 - zm[39:0]);
    end
  end
  assign diff     = 41'(z) - 41'(x_r);
  assign diff_mag = diff[40] ? 41'(-diff) : 41'(diff);
  assign kgain    = (den_r == 33'd0) ? '0 : q_r;

  // Correction magnitude, rounded half away from zero
  assign sm_round = a_prod + 74'd8388608;
  assign sm       = sm_round[63:24];

  assign tick_inc = tick_r + 16'd1;
  assign div_eff  = (cdiv_r == 16'd0) ? 16'd1 : cdiv_r;

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    scale_nxt     = scale_r;
    gain_nxt      = gain_r;
    qn_nxt        = qn_r;
    rn_nxt        = rn_r;
    cdiv_nxt      = cdiv_r;
    last_nxt      = last_r;
    acc_nxt       = acc_r;
    prev_nxt      = prev_r;
    x_nxt         = x_r;
    var_nxt       = var_r;
    ref_nxt       = ref_r;
    seen_nxt      = seen_r;
    tick_nxt      = tick_r;
    kind_nxt      = kind_r;
    zneg_nxt      = zneg_r;
    dneg_nxt      = dneg_r;
    accneg_nxt    = accneg_r;
    p_nxt         = p_r;
    den_nxt       = den_r;
    rem_nxt       = rem_r;
    q_nxt         = q_r;
    dcnt_nxt      = dcnt_r;
    pos_nxt       = pos_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    a_start       = 1'b0;
    b_start       = 1'b0;
    a_mcand       = {9'd0, gain_r};
    a_mplier      = delta_mag[32:0];
    b_mcand       = scale_r;
    b_mplier      = acc_mag;

    // Register writes
    if (cfg_wr) begin
      case (cfg_paddr[4:2])
        REG_POSITION_SCALE:    scale_nxt = cfg_pwdata;
        REG_VELOCITY_GAIN:     gain_nxt  = cfg_pwdata;
        REG_PROCESS_NOISE:     qn_nxt    = cfg_pwdata;
        REG_MEASUREMENT_NOISE: rn_nxt    = cfg_pwdata;
        REG_CONTROL_DIVIDER:   cdiv_nxt  = cfg_pwdata[15:0];
        default: ;
      endcase
    end

    // Divider advances on its own once loaded
    if (dcnt_r != 5'd0) begin
      rem_nxt  = {div_rem[32:0], 1'b0};
      q_nxt    = {q_r[K_BITS-2:0], div_ge};
      dcnt_nxt = dcnt_r - 5'd1;
    end

    // Drop the result once taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          kind_nxt  = in_data.kind;
          last_nxt  = rd;
          acc_nxt   = sat34(acc_sum);
          state_nxt = S_PREP;
        end
      end

      S_PREP: begin
        accneg_nxt = acc_r[31];
        b_start    = 1'b1;
        if (kind_r == KIND_MARKER) begin
          state_nxt = S_REFMUL;
        end else begin
          a_start   = 1'b1;
          zneg_nxt  = delta[33];
          p_nxt     = p_sat;
          den_nxt   = {1'b0, p_sat} + {1'b0, rn_r};
          rem_nxt   = {2'b00, p_sat};
          q_nxt     = '0;
          dcnt_nxt  = 5'(K_BITS);
          state_nxt = S_KRUN;
        end
      end

      S_REFMUL: begin
        if (!b_busy) begin
          state_nxt = S_REFEND;
        end
      end

      S_REFEND: begin
        // Latch the unwrapped position, then clear the total
        ref_nxt                = pos_round(b_prod, accneg_r);
        seen_nxt               = 1'b1;
        acc_nxt                = '0;
        res_nxt.position_mm    = '0;
        res_nxt.velocity_est   = sat40(x_r);
        res_nxt.reference_mm   = pos_round(b_prod, accneg_r);
        res_nxt.reference_seen = 1'b1;
        res_nxt.control_tick   = 1'b0;
        state_nxt              = S_FIN;
      end

      S_KRUN: begin
        if (!a_busy && !b_busy && dcnt_r == 5'd0) begin
          pos_nxt   = pos_round(b_prod, accneg_r);
          state_nxt = S_ZEND;
        end
      end

      S_ZEND: begin
        // Start the correction and variance products together
        dneg_nxt  = diff[40];
        a_start   = 1'b1;
        a_mcand   = diff_mag;
        a_mplier  = {8'd0, kgain};
        b_start   = 1'b1;
        b_mcand   = p_r;
        b_mplier  = {8'd0, K_ONE - kgain};
        state_nxt = S_UPD;
      end

      S_UPD: begin
        if (!a_busy && !b_busy) begin
          state_nxt = S_SEND;
        end
      end

      S_SEND: begin
        x_nxt    = dneg_r ? (x_r - sm) : (x_r + sm);
        var_nxt  = b_prod[55:24];
        prev_nxt = acc_r;
        res_nxt.position_mm    = pos_r;
        res_nxt.velocity_est   = sat40(dneg_r ? (x_r - sm) : (x_r + sm));
        res_nxt.reference_mm   = ref_r;
        res_nxt.reference_seen = seen_r;
        if (tick_inc >= div_eff) begin
          tick_nxt             = '0;
          res_nxt.control_tick = 1'b1;
        end else begin
          tick_nxt             = tick_inc;
          res_nxt.control_tick = 1'b0;
        end
        state_nxt = S_FIN;
      end

      S_FIN: begin
        // Hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // State and registered outputs
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    zneg_r     <= zneg_nxt;
    dneg_r     <= dneg_nxt;
    accneg_r   <= accneg_nxt;
    p_r        <= p_nxt;
    den_r      <= den_nxt;
    rem_r      <= rem_nxt;
    q_r        <= q_nxt;
    pos_r      <= pos_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      dcnt_r      <= '0;
      scale_r     <= RST_POSITION_SCALE;
      gain_r      <= RST_VELOCITY_GAIN;
      qn_r        <= RST_PROCESS_NOISE;
      rn_r        <= RST_MEASUREMENT_NOISE;
      cdiv_r      <= RST_CONTROL_DIVIDER;
      last_r      <= '0;
      acc_r       <= '0;
      prev_r      <= '0;
      x_r         <= '0;
      var_r       <= '0;
      ref_r       <= '0;
      seen_r      <= 1'b0;
      tick_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      dcnt_r      <= dcnt_nxt;
      scale_r     <= scale_nxt;
      gain_r      <= gain_nxt;
      qn_r        <= qn_nxt;
      rn_r        <= rn_nxt;
      cdiv_r      <= cdiv_nxt;
      last_r      <= last_nxt;
      acc_r       <= acc_nxt;
      prev_r      <= prev_nxt;
      x_r         <= x_nxt;
      var_r       <= var_nxt;
      ref_r       <= ref_nxt;
      seen_r      <= seen_nxt;
      tick_r      <= tick_nxt;
    end
  end

  // Register read-back
  always_comb begin
    case (cfg_paddr[4:2])
      REG_POSITION_SCALE:    cfg_prdata = scale_r;
      REG_VELOCITY_GAIN:     cfg_prdata = gain_r;
      REG_PROCESS_NOISE:     cfg_prdata = qn_r;
      REG_MEASUREMENT_NOISE: cfg_prdata = rn_r;
      REG_CONTROL_DIVIDER:   cfg_prdata = {16'd0, cdiv_r};
      default:               cfg_prdata = '0;
    endcase
  end

  assign cfg_pready = 1'b1;
  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

endmodule : encoder_position_velocity_kalman
`default_nettype wire

>>> hw/rtl/epvk_chk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Encoder position / velocity port checker
// Watches the top level's ports over time; attached by bind.
// ----------------------------------------------------------------------------
module epvk_chk
  import epvk_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire out_item_t         out_data
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // One beat at a time: ready drops after an accepted beat
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a beat is in work");

  // Once a marker has been seen, the next result still reports it
  a_seen_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.reference_seen |=> !out_valid || out_data.reference_seen)
    else $error("reference flag cleared without reset");

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

endmodule : epvk_chk

bind encoder_position_velocity_kalman epvk_chk u_epvk_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_data    (out_data)
);
`default_nettype wire

>>> sim/encoder_position_velocity_kalman_test.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Encoder position / Kalman velocity testbench
// Streams directed and random encoder readings and reference markers into the
// block under several register settings, predicts every readout with a local
// model of the unwrap, scaling, Kalman filter and period counter, and checks
// each readout field by field while both handshake sides idle and stall.
// ----------------------------------------------------------------------------
module encoder_position_velocity_kalman_test;
  import epvk_pkg::*;

  // Signed clamp limits and filter constants
  localparam longint    INT_TOP      = 64'sd2147483647;
  localparam longint    INT_BOTTOM   = -64'sd2147483648;
  localparam longint    VEL_CEIL     = (64'sd1 <<< 39) - 1;
  localparam longint    VEL_FLOOR    = -(64'sd1 <<< 39);
  localparam bit [63:0] VEL_CEIL_MAG = (64'd1 << 39) - 1;
  localparam bit [63:0] K_UNITY      = 64'd1 << 24;
  localparam bit [63:0] K_HALF       = 64'd1 << 23;
  localparam bit [63:0] POS_HALF     = 64'd32768;
  localparam bit [63:0] P_CEIL       = 64'hFFFF_FFFF;
  localparam bit [15:0] HALF_SPAN    = 16'h8000;
  localparam int        COUNT_SPAN   = 65536;
  // Number of word slots the address decodes; those past the map are spare
  localparam int        REG_SLOTS    = 1 << (ADDR_W - 2);

  // Readout sink behaviour, switched at random intervals
  typedef enum logic [1:0] {SINK_FLOW, SINK_JITTER, SINK_CHOKE} sink_mode_t;

  logic      clk   = 1'b0;
  logic      rst_n = 1'b0;

  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data  = '0;

  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  logic              cfg_psel    = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite  = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr   = '0;
  logic [31:0]       cfg_pwdata  = '0;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  encoder_position_velocity_kalman dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Generous ceiling: ~2000 beats, each allowed the longest sender gap, the
  // slow sample path and a heavily choked sink, taken several times over.
  initial begin
    #40_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Shadow of the register file, updated on every write the bench issues
  // --------------------------------------------------------------------------
  bit [31:0] scale_reg   = RST_POSITION_SCALE;
  bit [31:0] gain_reg    = RST_VELOCITY_GAIN;
  bit [31:0] q_reg       = RST_PROCESS_NOISE;
  bit [31:0] r_reg       = RST_MEASUREMENT_NOISE;
  bit [15:0] divider_reg = RST_CONTROL_DIVIDER;

  // Tracking state of the predictor, mirroring the block after reset
  bit [15:0] last_rd      = '0;
  int        net_count    = 0;
  int        prev_count   = 0;
  longint    velocity_acc = 0;   // Q24.16 estimate, kept within 40 bits
  bit [31:0] variance_acc = '0;  // Q8.24
  int        ref_latch    = 0;
  bit        ref_flag     = 1'b0;
  bit [15:0] tick_cnt     = '0;

  // Queues and bookkeeping
  in_item_t  encoder_events[$];  // beats waiting to be driven
  out_item_t readouts_due[$];    // predicted readouts, oldest first
  int        beats_issued     = 0;
  int        readouts_checked = 0;
  int        markers_sent     = 0;
  int        ticks_predicted  = 0;
  int        settings_used    = 1;
  int        faults           = 0;

  // Stimulus helpers' state
  bit [15:0] stim_raw = '0;
  int        speed    = 0;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic int clamp32(longint v);
    if (v > INT_TOP) return int'(INT_TOP);
    if (v < INT_BOTTOM) return int'(INT_BOTTOM);
    return int'(v);
  endfunction

  function automatic bit [63:0] magnitude(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  // Total count times mm per count, Q0.32 * count -> Q16.16, half away from 0
  function automatic int scaled_mm();
    bit [63:0] prod;
    bit [63:0] rnd;
    prod = magnitude(net_count) * {32'd0, scale_reg};
    rnd  = (prod + POS_HALF) >> 16;
    return clamp32((net_count < 0) ? -longint'(rnd) : longint'(rnd));
  endfunction

  // One scalar Kalman step on the count change since the previous sample
  function automatic void filter_velocity();
    longint    delta;
    longint    z;
    longint    diff;
    bit [63:0] zm;
    bit [63:0] p;
    bit [63:0] den;
    bit [63:0] k;
    bit [63:0] sm;
    delta = longint'(net_count) - longint'(prev_count);
    zm    = magnitude(delta) * {32'd0, gain_reg};
    // Saturate the measurement to 40-bit signed
    if (delta < 0) z = (zm > VEL_CEIL_MAG + 1) ? VEL_FLOOR : -longint'(zm);
    else           z = (zm > VEL_CEIL_MAG) ? VEL_CEIL : longint'(zm);
    p = {32'd0, variance_acc} + {32'd0, q_reg};
    if (p > P_CEIL) p = P_CEIL;
    den = p + {32'd0, r_reg};
    // Zero noise sum leaves the gain at zero
    k = (den != 0) ? (p << 24) / den : 64'd0;
    diff = z - velocity_acc;
    sm   = (magnitude(diff) * k + K_HALF) >> 24;
    velocity_acc = (diff < 0) ? velocity_acc - longint'(sm) : velocity_acc + longint'(sm);
    variance_acc = 32'(((K_UNITY - k) * p) >> 24);
  endfunction

  function automatic out_item_t predict_readout(in_item_t beat);
    out_item_t res;
    bit [15:0] d;
    bit [15:0] div;
    int        step;
    res = '0;
    // Unwrap: exactly half the range counts as a forward step
    d    = beat.reading - last_rd;
    step = (d > HALF_SPAN) ? int'(d) - COUNT_SPAN : int'(d);
    net_count = clamp32(longint'(net_count) + step);
    last_rd   = beat.reading;
    if (beat.kind == KIND_MARKER) begin
      // Latch, flag and clear; filter, previous count and period untouched
      ref_latch = scaled_mm();
      ref_flag  = 1'b1;
      net_count = 0;
      markers_sent++;
    end else begin
      div = (divider_reg == 0) ? 16'd1 : divider_reg;
      filter_velocity();
      prev_count = net_count;
      tick_cnt   = tick_cnt + 16'd1;
      // A lowered divider that the counter already passed ticks at once
      if (tick_cnt >= div) begin
        res.control_tick = 1'b1;
        tick_cnt         = '0;
        ticks_predicted++;
      end
    end
    res.position_mm    = scaled_mm();
    res.velocity_est   = clamp32(velocity_acc);
    res.reference_mm   = ref_latch;
    res.reference_seen = ref_flag;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: feeds queued beats in bursts separated by random gaps, and
  // predicts each beat the moment the block takes it.
  // --------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (in_valid && in_ready) readouts_due.push_back(predict_readout(in_data));
      // Hold the beat while it waits; otherwise the slot is free this cycle
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (encoder_events.size() != 0) begin
          in_valid <= 1'b1;
          in_data  <= encoder_events.pop_front();
          beats_issued++;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            // End of burst: half the time run straight on, else idle for a
            // spread of gaps long enough to land on every stage of the work
            burst_left = $urandom_range(0, 11);
            gap_left   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 120);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks every readout beat against the oldest prediction and
  // throttles out_ready on its own changing pattern.
  // --------------------------------------------------------------------------
  sink_mode_t sink_mode = SINK_FLOW;
  int         sink_left = 0;

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, $signed(want), $signed(got));
      faults++;
    end
  endtask

  always @(posedge clk) begin : readout_monitor
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (readouts_due.size() == 0) begin
        $error("readout beat arrived with nothing predicted");
        faults++;
      end else begin
        want = readouts_due.pop_front();
        compare_field("position_mm", want.position_mm, out_data.position_mm);
        compare_field("velocity_est", want.velocity_est, out_data.velocity_est);
        compare_field("reference_mm", want.reference_mm, out_data.reference_mm);
        compare_field("reference_seen", 32'(want.reference_seen),
                      32'(out_data.reference_seen));
        compare_field("control_tick", 32'(want.control_tick), 32'(out_data.control_tick));
        readouts_checked++;
      end
    end
    // Switch sink behaviour when the current mode runs out
    if (sink_left > 0) begin
      sink_left--;
    end else begin
      sink_mode = sink_mode_t'($urandom_range(0, 2));
      sink_left = $urandom_range(20, 300);
    end
    case (sink_mode)
      SINK_FLOW:   out_ready <= 1'b1;
      SINK_JITTER: out_ready <= $urandom_range(0, 1);
      default:     out_ready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_event(logic kind, logic [15:0] raw);
    in_item_t ev;
    ev.kind    = kind;
    ev.reading = raw;
    encoder_events.push_back(ev);
    stim_raw = raw;
  endtask

  task automatic queue_step(logic kind, int step);
    queue_event(kind, stim_raw + 16'(step));
  endtask

  // Mostly smooth motion at a drifting speed, with wild readings, near
  // half-range jumps, standstill and the odd reference marker mixed in
  task automatic queue_motion(int n);
    int   step;
    int   pick;
    logic kind;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0) speed = int'($urandom_range(0, 2000)) - 1000;
      kind = ($urandom_range(0, 15) == 0) ? KIND_MARKER : KIND_SAMPLE;
      pick = $urandom_range(0, 99);
      if (pick < 65)      step = speed + int'($urandom_range(0, 40)) - 20;
      else if (pick < 80) step = $urandom_range(0, COUNT_SPAN - 1);
      else if (pick < 90) step = int'(HALF_SPAN) - 2 + int'($urandom_range(0, 4));
      else                step = 0;
      queue_step(kind, step);
    end
  endtask

  // Wait until every queued beat has gone and every readout has come back
  task automatic settle();
    while (encoder_events.size() != 0 || beats_issued != readouts_checked) @(posedge clk);
  endtask

  // Setup cycle then access cycle; the register takes the value on the
  // edge that ends the access cycle
  task automatic write_register(logic [2:0] idx, logic [31:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_W'({idx, 2'b00});
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_POSITION_SCALE:    scale_reg   = value;
      REG_VELOCITY_GAIN:     gain_reg    = value;
      REG_PROCESS_NOISE:     q_reg       = value;
      REG_MEASUREMENT_NOISE: r_reg       = value;
      REG_CONTROL_DIVIDER:   divider_reg = value[15:0];
      default: ;  // spare slots: drop
    endcase
  endtask

  // Spread of words: both extremes, flat random and log-spread magnitudes
  function automatic bit [31:0] pick_word();
    case ($urandom_range(0, 5))
      0:       return 32'hFFFF_FFFF;
      1:       return 32'd0;
      2:       return $urandom;
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  task automatic write_all(bit [31:0] scale, bit [31:0] gain, bit [31:0] q,
                           bit [31:0] r, bit [15:0] div);
    write_register(REG_POSITION_SCALE, scale);
    write_register(REG_VELOCITY_GAIN, gain);
    write_register(REG_PROCESS_NOISE, q);
    write_register(REG_MEASUREMENT_NOISE, r);
    write_register(REG_CONTROL_DIVIDER, {16'd0, div});
    settings_used++;
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    bit [31:0] r_pick;
    bit [15:0] div_pick;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset defaults: wrap both ways, exact half-range steps (counted forward)
    // and a near-half step back, markers with and without motion, enough samples for one period tick
    queue_event(KIND_SAMPLE, 16'h0000);
    queue_event(KIND_SAMPLE, 16'h0001);
    queue_event(KIND_SAMPLE, 16'hFFFF);
    queue_event(KIND_SAMPLE, 16'h7FFF);
    queue_event(KIND_SAMPLE, 16'hFFFF);
    queue_event(KIND_SAMPLE, 16'h8000);
    queue_event(KIND_MARKER, 16'h8064);
    queue_event(KIND_SAMPLE, 16'h8064);
    queue_event(KIND_MARKER, 16'hFFFF);
    queue_event(KIND_MARKER, 16'h0000);
    for (int i = 0; i < 4; i++) queue_step(KIND_SAMPLE, 300);
    settle();

    // Scale, gain and process noise at the top, R at one, divider dropped to
    // one; position and measurement both saturate, process noise pins p
    write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 16'd1);
    for (int i = 0; i < 3; i++) queue_step(KIND_SAMPLE, int'(HALF_SPAN));
    queue_step(KIND_MARKER, 0);
    queue_step(KIND_SAMPLE, 1 - int'(HALF_SPAN));
    queue_step(KIND_SAMPLE, 1 - int'(HALF_SPAN));
    settle();

    // Bottom of every register: zero noise sum and a zero divider
    write_all(32'd0, 32'd0, 32'd0, 32'd0, 16'd0);
    for (int i = 0; i < 3; i++) queue_step(KIND_SAMPLE, 1000);
    queue_step(KIND_MARKER, -5);
    settle();

    // Writes to the spare slots must leave the map alone
    for (int a = REG_CONTROL_DIVIDER + 1; a < REG_SLOTS; a++)
      write_register(3'(a), 32'hFFFF_FFFF);
    for (int i = 0; i < 2; i++) queue_step(KIND_SAMPLE, 77);
    settle();

    // Random settings, each followed by a long stretch of motion
    for (int ph = 0; ph < 6; ph++) begin
      r_pick = pick_word();
      if (r_pick == 0) r_pick = 32'd1;
      case ($urandom_range(0, 3))
        0:       div_pick = 16'hFFFF;
        1:       div_pick = 16'd1;
        default: div_pick = 16'($urandom_range(1, 24));
      endcase
      write_all(pick_word(), pick_word(), pick_word(), r_pick, div_pick);
      queue_motion(280);
      settle();
    end

    // Allow for any stray beat the block might still emit
    repeat (100) @(posedge clk);
    if (readouts_due.size() != 0) begin
      $error("%0d predicted readouts never arrived", readouts_due.size());
      faults++;
    end
    $display("Covered %0d encoder beats (%0d reference markers, %0d control ticks)",
             beats_issued, markers_sent, ticks_predicted);
    $display("across %0d register settings with bursty input and a throttled sink.",
             settings_used);
    if (faults == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule : encoder_position_velocity_kalman_test
`default_nettype wire
